@@ hdl/wblf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wblf_pkg
// shared constants, codes and types of the basis curve fusion engine
// ----------------------------------------------------------------------------
package wblf_pkg;

	localparam int CHANNELS   = 3;
	localparam int BASES      = 9;
	localparam int LEVELS     = 256;
	localparam int DEPTH      = CHANNELS * BASES * LEVELS;
	localparam int ADDR_W     = $clog2(DEPTH);

	localparam int CV_W       = 16;
	localparam int PROD_W     = 2 * CV_W;
	localparam int ACC_W      = 36;
	localparam int FRAC_BITS  = 28;
	localparam int FULL_SCALE = 255;
	localparam int PIX_W      = 8;
	localparam int CH_W       = 2;

	// result slots: pipeline stages plus output queue
	localparam int RES_SLOTS  = 4;
	localparam int SLOT_W     = $clog2(RES_SLOTS);
	localparam int CREDIT_W   = $clog2(RES_SLOTS + 1);

	typedef enum logic {
		OP_LOAD    = 1'b0,
		OP_COMPUTE = 1'b1
	} op_t;

	typedef struct packed {
		logic            valid;
		logic            ok;
		logic            last;
		logic [CH_W-1:0] ch;
	} ctl_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic [CH_W-1:0]  channel;
	} result_t;

endpackage
`default_nettype wire

@@ hdl/wblf_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wblf_in_if
// input item channel: load or compute transactions
// ----------------------------------------------------------------------------
interface wblf_in_if;
	logic               valid;
	logic               ready;
	logic               op;
	logic [1:0]         color_channel;
	logic [3:0]         basis;
	logic [7:0]         level;
	logic signed [15:0] weight;
	logic signed [15:0] curve_value;
	logic               last_basis;

	modport source (
		output valid, op, color_channel, basis, level, weight, curve_value,
			last_basis,
		input  ready
	);
	modport sink (
		input  valid, op, color_channel, basis, level, weight, curve_value,
			last_basis,
		output ready
	);
endinterface
`default_nettype wire

@@ hdl/wblf_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wblf_out_if
// result channel: enhanced pixel component
// ----------------------------------------------------------------------------
interface wblf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel_out;
	logic [1:0] channel_out;

	modport source (
		output valid, pixel_out, channel_out,
		input  ready
	);
	modport sink (
		input  valid, pixel_out, channel_out,
		output ready
	);
endinterface
`default_nettype wire

@@ hdl/wblf_curve_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wblf_curve_mem
// curve store: address decode, single-port synchronous ram, stage 1 regs
// ----------------------------------------------------------------------------
module wblf_curve_mem (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             accept,
	input  wire logic                             op,
	input  wire logic [wblf_pkg::CH_W-1:0]        color_channel,
	input  wire logic [3:0]                       basis,
	input  wire logic [7:0]                       level,
	input  wire logic signed [wblf_pkg::CV_W-1:0] weight,
	input  wire logic signed [wblf_pkg::CV_W-1:0] curve_value,
	input  wire logic                             last_basis,
	output wblf_pkg::ctl_t                        ctl_s1,
	output logic signed [wblf_pkg::CV_W-1:0]      weight_s1,
	output logic signed [wblf_pkg::CV_W-1:0]      rdata_s1
);

	logic signed [wblf_pkg::CV_W-1:0] mem [wblf_pkg::DEPTH];

	logic                        in_range;
	logic [wblf_pkg::ADDR_W-1:0] addr;
	logic                        wr_en;
	logic                        rd_en;

	assign in_range = (32'(color_channel) < wblf_pkg::CHANNELS)
		&& (32'(basis) < wblf_pkg::BASES)
		&& (32'(level) < wblf_pkg::LEVELS);

	// entry (c, b, l) lives at (c*BASES + b)*LEVELS + l
	assign addr = wblf_pkg::ADDR_W'((32'(color_channel) * wblf_pkg::BASES
		+ 32'(basis)) * wblf_pkg::LEVELS + 32'(level));

	assign wr_en = accept && in_range && (wblf_pkg::op_t'(op) == wblf_pkg::OP_LOAD);
	assign rd_en = accept && in_range && (wblf_pkg::op_t'(op) == wblf_pkg::OP_COMPUTE);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= curve_value;
		end
		if (rd_en) begin
			rdata_s1 <= mem[addr];
		end
	end

	always_ff @(posedge clk) begin
		weight_s1 <= weight;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid <= accept && (wblf_pkg::op_t'(op) == wblf_pkg::OP_COMPUTE);
			ctl_s1.ok    <= in_range;
			ctl_s1.last  <= last_basis;
			ctl_s1.ch    <= color_channel;
		end
	end

endmodule
`default_nettype wire

@@ hdl/wblf_mac.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wblf_mac
// weight times curve value, saturating accumulate, scale and clip
// ----------------------------------------------------------------------------
module wblf_mac (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire wblf_pkg::ctl_t                   ctl_s1,
	input  wire logic signed [wblf_pkg::CV_W-1:0] weight_s1,
	input  wire logic signed [wblf_pkg::CV_W-1:0] rdata_s1,
	output logic                                  res_valid,
	output wblf_pkg::result_t                     res_data
);

	localparam int SCALED_W = wblf_pkg::ACC_W - 1 + wblf_pkg::PIX_W;

	wblf_pkg::ctl_t                     ctl_s2;
	logic signed [wblf_pkg::PROD_W-1:0] prod_s2;

	logic signed [wblf_pkg::ACC_W-1:0]  acc_q;
	logic signed [wblf_pkg::ACC_W:0]    sum;
	logic signed [wblf_pkg::ACC_W-1:0]  sum_sat;

	logic                               valid_s3;
	logic [wblf_pkg::CH_W-1:0]          ch_s3;
	logic signed [wblf_pkg::ACC_W-1:0]  fin_s3;

	logic [SCALED_W-1:0]                scaled;
	logic [SCALED_W-wblf_pkg::FRAC_BITS-1:0] whole;

	// stage 2: product, zero for an out-of-range index
	always_ff @(posedge clk) begin
		if (ctl_s1.ok) begin
			prod_s2 <= weight_s1 * rdata_s1;
		end else begin
			prod_s2 <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
		end
	end

	// stage 3: accumulate with saturation at the signed range
	assign sum = (wblf_pkg::ACC_W+1)'(acc_q) + (wblf_pkg::ACC_W+1)'(prod_s2);

	always_comb begin
		if (sum[wblf_pkg::ACC_W] != sum[wblf_pkg::ACC_W-1]) begin
			sum_sat = sum[wblf_pkg::ACC_W]
				? {1'b1, {(wblf_pkg::ACC_W-1){1'b0}}}
				: {1'b0, {(wblf_pkg::ACC_W-1){1'b1}}};
		end else begin
			sum_sat = sum[wblf_pkg::ACC_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= ctl_s2.valid && ctl_s2.last;
			if (ctl_s2.valid) begin
				acc_q <= ctl_s2.last ? '0 : sum_sat;
			end
		end
	end

	always_ff @(posedge clk) begin
		fin_s3 <= sum_sat;
		ch_s3  <= ctl_s2.ch;
	end

	// output scale: floor(acc * 255 / 2^28), negative gives zero
	assign scaled = SCALED_W'(fin_s3[wblf_pkg::ACC_W-2:0])
		* SCALED_W'(wblf_pkg::FULL_SCALE);
	assign whole = scaled[SCALED_W-1:wblf_pkg::FRAC_BITS];

	always_comb begin
		res_valid        = valid_s3;
		res_data.channel = ch_s3;
		if (fin_s3[wblf_pkg::ACC_W-1]) begin
			res_data.pixel = '0;
		end else if (32'(whole) > wblf_pkg::FULL_SCALE) begin
			res_data.pixel = wblf_pkg::PIX_W'(wblf_pkg::FULL_SCALE);
		end else begin
			res_data.pixel = wblf_pkg::PIX_W'(whole);
		end
	end

endmodule
`default_nettype wire

@@ hdl/wblf_out_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wblf_out_fifo
// small result queue in front of the output channel
// ----------------------------------------------------------------------------
module wblf_out_fifo (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire wblf_pkg::result_t push_data,
	input  wire logic              pop,
	output logic                   not_empty,
	output wblf_pkg::result_t      head
);

	wblf_pkg::result_t                slot_q [wblf_pkg::RES_SLOTS];
	logic [wblf_pkg::SLOT_W-1:0]      wr_ptr_q;
	logic [wblf_pkg::SLOT_W-1:0]      rd_ptr_q;
	logic [wblf_pkg::CREDIT_W-1:0]    cnt_q;

	assign not_empty = (cnt_q != '0);
	assign head      = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> cnt_q < wblf_pkg::CREDIT_W'(wblf_pkg::RES_SLOTS))
		else $error("result queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != '0)
		else $error("result queue underflow");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == '0 || cnt_q == wblf_pkg::CREDIT_W'(wblf_pkg::RES_SLOTS)
			|-> wr_ptr_q == rd_ptr_q)
		else $error("result queue pointers disagree with count");
`endif

endmodule
`default_nettype wire

@@ hdl/weighted_basis_lut_fusion.sv @@
`timescale 1ns / 1ps
`default_nettype none
// a compute transaction marked last shows its result once it has passed stages 1, 2 and 3 and the result queue
// throughput: one load or compute transaction per cycle while credits allow intake, set by the single curve ram port
// the accumulator and multiplier each sit in their own stage, so terms chain back to back
// a credit counter holds intake once four results are in flight or queued
// reset: async active-low clears pipeline valids, accumulator, queue and credits
// reset: the curve ram is not cleared; an entry reads garbage until written
// ----------------------------------------------------------------------------
// weighted_basis_lut_fusion
// basis curve fusion engine: weighted lookups summed and scaled to a pixel
// ----------------------------------------------------------------------------
module weighted_basis_lut_fusion (
	input  wire logic clk,
	input  wire logic arst_n,
	wblf_in_if.sink   item,
	wblf_out_if.source result
);

	logic                                accept;
	logic                                res_accept;
	logic                                closes_sum;

	wblf_pkg::ctl_t                      ctl_s1;
	logic signed [wblf_pkg::CV_W-1:0]    weight_s1;
	logic signed [wblf_pkg::CV_W-1:0]    rdata_s1;

	logic                                res_valid;
	wblf_pkg::result_t                   res_data;
	logic                                q_not_empty;
	wblf_pkg::result_t                   q_head;

	// results accepted at the input but not yet delivered
	logic [wblf_pkg::CREDIT_W-1:0]       credit_q;

	// ready is registered state only, no path from the output side
	assign item.ready = (credit_q < wblf_pkg::CREDIT_W'(wblf_pkg::RES_SLOTS));
	assign accept     = item.valid && item.ready;
	assign closes_sum = accept && item.last_basis
		&& (wblf_pkg::op_t'(item.op) == wblf_pkg::OP_COMPUTE);
	assign res_accept = result.valid && result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else begin
			unique case ({closes_sum, res_accept})
				2'b10:   credit_q <= credit_q + 1'b1;
				2'b01:   credit_q <= credit_q - 1'b1;
				default: credit_q <= credit_q;
			endcase
		end
	end

	// stage 1: curve ram write on load, read on compute
	wblf_curve_mem u_mem (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.op            (item.op),
		.color_channel (item.color_channel),
		.basis         (item.basis),
		.level         (item.level),
		.weight        (item.weight),
		.curve_value   (item.curve_value),
		.last_basis    (item.last_basis),
		.ctl_s1        (ctl_s1),
		.weight_s1     (weight_s1),
		.rdata_s1      (rdata_s1)
	);

	// stages 2 and 3: multiply, accumulate, scale
	wblf_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_s1    (ctl_s1),
		.weight_s1 (weight_s1),
		.rdata_s1  (rdata_s1),
		.res_valid (res_valid),
		.res_data  (res_data)
	);

	// result queue decouples the output stall from the pipeline
	wblf_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res_data),
		.pop       (res_accept),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	assign result.valid       = q_not_empty;
	assign result.pixel_out   = q_head.pixel;
	assign result.channel_out = q_head.channel;

`ifndef SYNTHESIS
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		credit_q <= wblf_pkg::CREDIT_W'(wblf_pkg::RES_SLOTS))
		else $error("credit counter out of range");
	a_out_has_credit: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> credit_q != '0)
		else $error("result shown without a pending transaction");
	a_last_reaches_mac: assert property (@(posedge clk) disable iff (!arst_n)
		closes_sum |=> ctl_s1.valid && ctl_s1.last)
		else $error("closing transaction lost before the multiplier");
	a_push_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s1.valid && ctl_s1.last |-> ##2 res_valid)
		else $error("closing transaction did not reach the result queue");
`endif

endmodule
`default_nettype wire
